>>> design/glos_pkg.sv
// Shared types, constants and helpers for the grid line-of-sight block.
`default_nettype none

package glos_pkg;

  // Grid memory geometry and height word width.
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int HEIGHT_BITS = 32;

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_BITS  = $clog2(CELL_COUNT);

  // Fixed widths of the item fields and configuration registers.
  localparam int COORD_BITS     = 6;
  localparam int LEVEL_BITS     = 32;
  localparam int CFG_BITS       = 7;
  localparam int CFG_INDEX_BITS = 2;

  // Bresenham walker arithmetic.
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Operation codes of the input item.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [CFG_BITS-1:0] GRID_WIDTH_RESET  = 7'd64;
  localparam logic [CFG_BITS-1:0] GRID_HEIGHT_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_QUERY,
    CMD_TRIVIAL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                      kind;
    logic [COORD_BITS-1:0]          src_x;
    logic [COORD_BITS-1:0]          src_y;
    logic [COORD_BITS-1:0]          dst_x;
    logic [COORD_BITS-1:0]          dst_y;
    logic signed [HEIGHT_BITS-1:0]  level;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } back_state_t;

  // Sign-extend or wrap a raw 32-bit level to the stored height width.
  function automatic logic signed [HEIGHT_BITS-1:0] to_height(
    input logic signed [LEVEL_BITS-1:0] raw
  );
    return HEIGHT_BITS'(raw);
  endfunction

endpackage

`default_nettype wire

>>> design/glos_front.sv
// Front end: accepts items, classifies them and builds queue commands.
`default_nettype none

module glos_front
  import glos_pkg::*;
(
  input  wire logic                   start,
  input  wire logic                   queue_full,
  input  wire logic                   operation,
  input  wire logic [COORD_BITS-1:0]  source_x,
  input  wire logic [COORD_BITS-1:0]  source_y,
  input  wire logic [COORD_BITS-1:0]  target_x,
  input  wire logic [COORD_BITS-1:0]  target_y,
  input  wire logic [LEVEL_BITS-1:0]  ground_level,
  input  wire logic [LEVEL_BITS-1:0]  blocker_level,
  input  wire logic [LEVEL_BITS-1:0]  eye_level,
  output logic                        push,
  output cmd_t                        cmd
);

  logic                          accept;
  logic                          in_memory;
  logic signed [HEIGHT_BITS-1:0] ground_h;
  logic signed [HEIGHT_BITS-1:0] blocker_h;

  assign accept    = start && !queue_full;
  assign ground_h  = to_height($signed(ground_level));
  assign blocker_h = to_height($signed(blocker_level));
  assign in_memory = (32'(source_x) < 32'(MAX_COLUMNS)) &&
                     (32'(source_y) < 32'(MAX_ROWS));

  always_comb begin
    cmd.src_x = source_x;
    cmd.src_y = source_y;
    cmd.dst_x = target_x;
    cmd.dst_y = target_y;
    if (operation == OP_QUERY) begin
      cmd.level = to_height($signed(eye_level));
      if (source_x == target_x && source_y == target_y) begin
        cmd.kind = CMD_TRIVIAL;
      end else begin
        cmd.kind = CMD_QUERY;
      end
      push = accept;
    end else begin
      // Keep the higher of ground and blocker top.
      cmd.level = (blocker_h > ground_h) ? blocker_h : ground_h;
      cmd.kind  = CMD_WRITE;
      // Drop writes that fall outside the memory.
      push      = accept && in_memory;
    end
  end

endmodule

`default_nettype wire

>>> design/glos_queue.sv
// Short command queue between the front end and the walker.
`default_nettype none

module glos_queue
  import glos_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head
);

  cmd_t                 entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];

  function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] p);
    if (32'(p) == QUEUE_DEPTH - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> design/glos_back.sv
// Back end: height memory, cell writes and the Bresenham line walker.
`default_nettype none

module glos_back
  import glos_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire cmd_t                head,
  output logic                     pop,
  input  wire logic [CFG_BITS-1:0] grid_width,
  input  wire logic [CFG_BITS-1:0] grid_height,
  output logic                     out_valid,
  output logic                     out_visible
);

  logic signed [HEIGHT_BITS-1:0] mem [CELL_COUNT];
  logic signed [HEIGHT_BITS-1:0] rd_data_r;

  back_state_t                   state_r, state_nxt;
  logic [COORD_BITS-1:0]         x_r, x_nxt, y_r, y_nxt;
  logic [COORD_BITS-1:0]         tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [DELTA_BITS-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic                          neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic signed [ERR_BITS-1:0]    err_r, err_nxt;
  logic signed [HEIGHT_BITS-1:0] eye_r, eye_nxt;
  logic                          chk_valid_r, chk_valid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_visible_r, out_visible_nxt;

  logic                          wr_en, rd_en;
  logic [ADDR_BITS-1:0]          wr_addr, rd_addr;
  logic                          pop_trivial;

  logic signed [ERR_BITS:0]      e2;
  logic                          step_x, step_y;
  logic [COORD_BITS-1:0]         nx, ny;
  logic [COORD_BITS-1:0]         abs_dx, abs_dy;
  logic                          blocks, at_target, next_in_grid;

  function automatic logic [ADDR_BITS-1:0] cell_addr(
    input logic [COORD_BITS-1:0] cx,
    input logic [COORD_BITS-1:0] cy
  );
    return ADDR_BITS'(ADDR_BITS'(cy) * ADDR_BITS'(MAX_COLUMNS)) + ADDR_BITS'(cx);
  endfunction

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  // One Bresenham step from the current cell.
  assign e2     = {err_r, 1'b0};
  assign step_x = (e2 >= (ERR_BITS + 1)'(dy_r));
  assign step_y = (e2 <= (ERR_BITS + 1)'(dx_r));
  assign nx     = step_x ? (neg_x_r ? x_r - 1'b1 : x_r + 1'b1) : x_r;
  assign ny     = step_y ? (neg_y_r ? y_r - 1'b1 : y_r + 1'b1) : y_r;

  assign at_target    = (nx == tx_r) && (ny == ty_r);
  assign blocks       = chk_valid_r && (rd_data_r > eye_r);
  assign next_in_grid = ({1'b0, nx} < grid_width) && ({1'b0, ny} < grid_height) &&
                        (32'(nx) < MAX_COLUMNS) && (32'(ny) < MAX_ROWS);

  assign abs_dx = (head.dst_x >= head.src_x) ? head.dst_x - head.src_x
                                             : head.src_x - head.dst_x;
  assign abs_dy = (head.dst_y >= head.src_y) ? head.dst_y - head.src_y
                                             : head.src_y - head.dst_y;

  assign wr_addr = cell_addr(head.src_x, head.src_y);
  assign rd_addr = cell_addr(nx, ny);

  always_comb begin
    state_nxt       = state_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    tx_nxt          = tx_r;
    ty_nxt          = ty_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    neg_x_nxt       = neg_x_r;
    neg_y_nxt       = neg_y_r;
    err_nxt         = err_r;
    eye_nxt         = eye_r;
    chk_valid_nxt   = 1'b0;
    out_valid_nxt   = 1'b0;
    out_visible_nxt = out_visible_r;
    pop             = 1'b0;
    pop_trivial     = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.kind)
            CMD_WRITE: begin
              wr_en = 1'b1;
            end
            CMD_TRIVIAL: begin
              pop_trivial     = 1'b1;
              out_valid_nxt   = 1'b1;
              out_visible_nxt = 1'b1;
            end
            CMD_QUERY: begin
              x_nxt         = head.src_x;
              y_nxt         = head.src_y;
              tx_nxt        = head.dst_x;
              ty_nxt        = head.dst_y;
              dx_nxt        = $signed({1'b0, abs_dx});
              dy_nxt        = -$signed({1'b0, abs_dy});
              neg_x_nxt     = (head.dst_x < head.src_x);
              neg_y_nxt     = (head.dst_y < head.src_y);
              err_nxt       = ERR_BITS'($signed({1'b0, abs_dx})) -
                              ERR_BITS'($signed({1'b0, abs_dy}));
              eye_nxt       = head.level;
              chk_valid_nxt = 1'b0;
              state_nxt     = ST_WALK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // The previous cell comes before the next one on the line.
        if (blocks) begin
          out_valid_nxt   = 1'b1;
          out_visible_nxt = 1'b0;
          state_nxt       = ST_IDLE;
        end else if (at_target) begin
          out_valid_nxt   = 1'b1;
          out_visible_nxt = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          x_nxt         = nx;
          y_nxt         = ny;
          err_nxt       = err_r + (step_x ? ERR_BITS'(dy_r) : '0) +
                          (step_y ? ERR_BITS'(dx_r) : '0);
          rd_en         = next_in_grid;
          chk_valid_nxt = next_in_grid;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      chk_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      out_visible_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      chk_valid_r   <= chk_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      out_visible_r <= out_visible_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    tx_r    <= tx_nxt;
    ty_r    <= ty_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    neg_x_r <= neg_x_nxt;
    neg_y_r <= neg_y_nxt;
    err_r   <= err_nxt;
    eye_r   <= eye_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= head.level;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_WALK) || $past(pop_trivial))
    else $error("result strobe without a finished walk or trivial query");

  a_check_has_read: assert property (@(posedge clk) disable iff (!rst_n)
    chk_valid_r |-> $past(rd_en))
    else $error("cell compare without a preceding memory read");

  a_walk_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |=> state_r == ST_WALK || out_valid_r)
    else $error("walk ended without a result");
`endif

endmodule

`default_nettype wire

>>> design/grid_line_of_sight.sv
// Top level of the grid line-of-sight block: config registers and the three parts.
//
// Channel   Direction  Handshake                     Payload
// input     in         start & !busy                 in_operation .. in_eye_level
// result    out        out_valid, one-cycle strobe   out_visible
// config    in         cfg_we                        cfg_index, cfg_wdata
//
// A write updates one memory cell; a query whose line has n cells strictly
// between its endpoints (n <= 62) walks them in order, reading each walked cell
// that lies inside the grid, through the walker's single read port. Source equal
// to target needs no walk. A two-entry queue lets new transactions in while the
// walker runs; busy rises only when that queue is full. Reset is synchronous,
// active low, and clears control state; the height memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module grid_line_of_sight
  import glos_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input transactions
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_operation,
  input  wire logic [COORD_BITS-1:0]     in_source_x,
  input  wire logic [COORD_BITS-1:0]     in_source_y,
  input  wire logic [COORD_BITS-1:0]     in_target_x,
  input  wire logic [COORD_BITS-1:0]     in_target_y,
  input  wire logic [LEVEL_BITS-1:0]     in_ground_level,
  input  wire logic [LEVEL_BITS-1:0]     in_blocker_level,
  input  wire logic [LEVEL_BITS-1:0]     in_eye_level,
  // results
  output logic                           out_valid,
  output logic                           out_visible,
  // configuration writes
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_wdata
);

  logic [CFG_BITS-1:0] grid_width_r, grid_width_nxt;
  logic [CFG_BITS-1:0] grid_height_r, grid_height_nxt;

  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  assign busy = queue_full;

  // Grid size registers; unknown indexes are ignored.
  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width_nxt  = cfg_wdata;
        REG_GRID_HEIGHT: grid_height_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RESET;
      grid_height_r <= GRID_HEIGHT_RESET;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  // Classify the transaction and compute the stored top for writes.
  glos_front u_front (
    .start         (start),
    .queue_full    (queue_full),
    .operation     (in_operation),
    .source_x      (in_source_x),
    .source_y      (in_source_y),
    .target_x      (in_target_x),
    .target_y      (in_target_y),
    .ground_level  (in_ground_level),
    .blocker_level (in_blocker_level),
    .eye_level     (in_eye_level),
    .push          (push),
    .cmd           (push_cmd)
  );

  // Hold commands while the walker is busy with a long line.
  glos_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Write cells and walk query lines, one cell per cycle.
  glos_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .out_valid   (out_valid),
    .out_visible (out_visible)
  );

endmodule

`default_nettype wire

>>> dv/tb_grid_line_of_sight.sv
// Self-checking testbench for grid_line_of_sight: directed table, preload, random phases.
module tb_grid_line_of_sight;
  import glos_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 9;
  // Room for two queued transactions plus one walk in flight to finish.
  localparam int SETTLE_CYCLES = 256;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int PHASE_ITEMS   = 58;
  localparam int PHASE_COUNT   = 8;
  localparam int BOOT_ROWS     = 4;
  localparam int CELLS         = MAX_COLUMNS * MAX_ROWS;
  // Full-width rows written before the directed table so long walks stay on written cells.
  localparam int BAND_ROWS     = 4;
  localparam int QUERY_TRIES   = 8;

  // Register indexes the block does not decode; writes to them must be dropped.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic                  op;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
    logic [LEVEL_BITS-1:0] ground;
    logic [LEVEL_BITS-1:0] blocker;
    logic [LEVEL_BITS-1:0] eye;
  } grid_txn_t;

  // One row of the directed table; typed rows carry their answer, others use the predictor.
  typedef struct packed {
    grid_txn_t txn;
    bit        typed;
    bit        want;
  } stim_row_t;

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      start            = 1'b0;
  logic                      busy;
  logic                      in_operation     = OP_WRITE;
  logic [COORD_BITS-1:0]     in_source_x      = '0;
  logic [COORD_BITS-1:0]     in_source_y      = '0;
  logic [COORD_BITS-1:0]     in_target_x      = '0;
  logic [COORD_BITS-1:0]     in_target_y      = '0;
  logic [LEVEL_BITS-1:0]     in_ground_level  = '0;
  logic [LEVEL_BITS-1:0]     in_blocker_level = '0;
  logic [LEVEL_BITS-1:0]     in_eye_level     = '0;
  logic                      out_valid;
  logic                      out_visible;
  logic                      cfg_we           = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index        = REG_GRID_WIDTH;
  logic [CFG_BITS-1:0]       cfg_wdata        = '0;

  // Predictor state: shadow of the height memory and of the grid size registers.
  logic signed [HEIGHT_BITS-1:0] height_map [CELLS];
  bit                            written    [CELLS];
  int                            grid_w;
  int                            grid_h;

  // Visibility answers still owed by the block, oldest first.
  bit        pending_visibility [$];
  stim_row_t stim_table [$];
  int        n_errors = 0;
  bit        idle_on  = 1'b1;
  bit        want_visible;

  grid_line_of_sight dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_source_x      (in_source_x),
    .in_source_y      (in_source_y),
    .in_target_x      (in_target_x),
    .in_target_y      (in_target_y),
    .in_ground_level  (in_ground_level),
    .in_blocker_level (in_blocker_level),
    .in_eye_level     (in_eye_level),
    .out_valid        (out_valid),
    .out_visible      (out_visible),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Walk the Bresenham line from source to target and report whether no cell strictly
  // between the endpoints rises above the eye. Cells off the configured grid or off the
  // memory are transparent; identical endpoints are always visible.
  function automatic bit line_is_clear(grid_txn_t t);
    int x0, y0, x1, y1, dx, dy, stx, sty, err, e2, x, y, n;
    logic signed [HEIGHT_BITS-1:0] eye;
    eye = HEIGHT_BITS'($signed(t.eye));
    x0 = int'(t.sx);
    y0 = int'(t.sy);
    x1 = int'(t.tx);
    y1 = int'(t.ty);
    if (x0 == x1 && y0 == y1) return 1'b1;
    dx  = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    dy  = -((y1 > y0) ? (y1 - y0) : (y0 - y1));
    stx = (x0 < x1) ? 1 : -1;
    sty = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    x   = x0;
    y   = y0;
    for (n = 0; n < 4 * (MAX_COLUMNS + MAX_ROWS + 64); n++) begin
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x   += stx;
      end
      if (e2 <= dx) begin
        err += dx;
        y   += sty;
      end
      if (x == x1 && y == y1) return 1'b1;
      if (x >= 0 && y >= 0 && x < grid_w && y < grid_h && x < MAX_COLUMNS && y < MAX_ROWS
          && height_map[y * MAX_COLUMNS + x] > eye) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Walk the same line and return the first in-grid cell on it that was never written,
  // or -1 when the block would read only written cells.
  function automatic int first_unwritten(grid_txn_t t);
    int x1, y1, dx, dy, stx, sty, err, e2, x, y, n;
    x  = int'(t.sx);
    y  = int'(t.sy);
    x1 = int'(t.tx);
    y1 = int'(t.ty);
    if (x == x1 && y == y1) return -1;
    dx  = (x1 > x) ? (x1 - x) : (x - x1);
    dy  = -((y1 > y) ? (y1 - y) : (y - y1));
    stx = (x < x1) ? 1 : -1;
    sty = (y < y1) ? 1 : -1;
    err = dx + dy;
    for (n = 0; n < 4 * (MAX_COLUMNS + MAX_ROWS + 64); n++) begin
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x   += stx;
      end
      if (e2 <= dx) begin
        err += dx;
        y   += sty;
      end
      if (x == x1 && y == y1) return -1;
      if (x >= 0 && y >= 0 && x < grid_w && y < grid_h && x < MAX_COLUMNS && y < MAX_ROWS
          && !written[y * MAX_COLUMNS + x]) return y * MAX_COLUMNS + x;
    end
    return -1;
  endfunction

  // Heights: mostly a narrow band around zero so lines are sometimes clear, plus zero,
  // the signed extremes and full-width noise.
  function automatic logic [LEVEL_BITS-1:0] rand_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h7FFF_FFFE;
          default: return 32'h8000_0001;
        endcase
      end
      2: return $urandom;
      default: return LEVEL_BITS'($urandom_range(0, 16) - 8);
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 63) return 6'd63;
    return COORD_BITS'(v);
  endfunction

  // Prefer coordinates inside the configured area so narrow grids still see real walks.
  function automatic logic [COORD_BITS-1:0] pick_coord(int lim);
    if (lim > MAX_COLUMNS) lim = MAX_COLUMNS;
    if (lim > 0 && $urandom_range(0, 9) < 7) return COORD_BITS'($urandom_range(0, lim - 1));
    return COORD_BITS'($urandom_range(0, 63));
  endfunction

  function automatic grid_txn_t random_txn();
    grid_txn_t t;
    int        d;
    t.op      = ($urandom_range(0, 99) < 35) ? OP_WRITE : OP_QUERY;
    t.sx      = pick_coord(grid_w);
    t.sy      = pick_coord(grid_h);
    // half of the sources sit in the preloaded band
    if ($urandom_range(0, 1) == 0) t.sy = COORD_BITS'($urandom_range(0, BAND_ROWS - 1));
    t.tx      = COORD_BITS'($urandom_range(0, 63));
    t.ty      = COORD_BITS'($urandom_range(0, 63));
    t.ground  = rand_level();
    t.blocker = ($urandom_range(0, 2) == 0) ? '0 : rand_level();
    t.eye     = ($urandom_range(0, 9) < 6) ? LEVEL_BITS'($urandom_range(0, 12) - 4)
                                           : rand_level();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // short line near the source
        t.tx = clamp_coord(int'(t.sx) + int'($urandom_range(0, 8)) - 4);
        t.ty = clamp_coord(int'(t.sy) + int'($urandom_range(0, 8)) - 4);
      end
      4: begin
        t.tx = t.sx;
        t.ty = t.sy;
      end
      5: t.ty = t.sy;
      6: t.tx = t.sx;
      7: begin
        d    = $urandom_range(1, 63);
        t.tx = clamp_coord(($urandom_range(0, 1) != 0) ? int'(t.sx) + d : int'(t.sx) - d);
        t.ty = clamp_coord(($urandom_range(0, 1) != 0) ? int'(t.sy) + d : int'(t.sy) - d);
      end
      8: begin
        t.tx = pick_coord(grid_w);
        t.ty = pick_coord(grid_h);
      end
      default: t.ty = COORD_BITS'($urandom_range(0, BAND_ROWS - 1));
    endcase
    return t;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void add_row(logic op, int sx, int sy, int tx, int ty,
                                  logic [LEVEL_BITS-1:0] g, logic [LEVEL_BITS-1:0] b,
                                  logic [LEVEL_BITS-1:0] e, bit typed, bit want);
    stim_row_t r;
    r.txn.op      = op;
    r.txn.sx      = COORD_BITS'(sx);
    r.txn.sy      = COORD_BITS'(sy);
    r.txn.tx      = COORD_BITS'(tx);
    r.txn.ty      = COORD_BITS'(ty);
    r.txn.ground  = g;
    r.txn.blocker = b;
    r.txn.eye     = e;
    r.typed       = typed;
    r.want        = want;
    stim_table.push_back(r);
  endfunction

  // Present one transaction from the current rising edge and hold it until the block takes
  // it (start high, busy low at an edge). Update the shadow memory or queue the answer at
  // the accepting edge, then idle for a random gap.
  task automatic issue_txn(grid_txn_t t, bit typed, bit want);
    int gap;
    logic signed [HEIGHT_BITS-1:0] g, b;
    start            <= 1'b1;
    in_operation     <= t.op;
    in_source_x      <= t.sx;
    in_source_y      <= t.sy;
    in_target_x      <= t.tx;
    in_target_y      <= t.ty;
    in_ground_level  <= t.ground;
    in_blocker_level <= t.blocker;
    in_eye_level     <= t.eye;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (t.op == OP_QUERY) begin
      pending_visibility.push_back(typed ? want : line_is_clear(t));
    end else if (t.sx < MAX_COLUMNS && t.sy < MAX_ROWS) begin
      // keep the larger of ground and blocker; a zero blocker still floors the top at zero
      g = HEIGHT_BITS'($signed(t.ground));
      b = HEIGHT_BITS'($signed(t.blocker));
      height_map[t.sy * MAX_COLUMNS + t.sx] = (b > g) ? b : g;
      written[t.sy * MAX_COLUMNS + t.sx]    = 1'b1;
    end
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start, wait for every owed answer, then let queued writes drain out of the walker.
  task automatic drain();
    start <= 1'b0;
    while (pending_visibility.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both size registers on back-to-back edges, optionally followed by a write to an
  // undecoded index, holding cfg_we high across the burst.
  task automatic program_grid(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h,
                              bit add_junk, logic [CFG_INDEX_BITS-1:0] junk_idx);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    if (add_junk) begin
      cfg_index <= junk_idx;
      cfg_wdata <= CFG_BITS'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    grid_w = int'(w);
    grid_h = int'(h);
  endtask

  // Result monitor: the receiver cannot stall, so check every strobe against the oldest
  // owed answer.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_visibility.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: expected none, actual visible=%0b",
                 $time, out_visible);
      end else begin
        want_visible = pending_visibility.pop_front();
        if (out_visible !== want_visible) begin
          n_errors++;
          $display("%0t: visible mismatch: expected %0b, actual %0b",
                   $time, want_visible, out_visible);
        end
      end
    end
  end

  initial begin
    grid_txn_t                t;
    int                       i, c, p, k, r, u;
    logic [CFG_BITS-1:0]      pw, ph;
    bit                       junk;
    logic [CFG_INDEX_BITS-1:0] junk_idx;

    // Rows that read no memory run straight after reset.
    add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 1, 1);
    add_row(OP_QUERY, 63, 63, 63, 63, 0, 0, 32'h7FFF_FFFF, 1, 1);
    add_row(OP_QUERY, 0, 0, 1, 1, 0, 0, 32'h8000_0000, 1, 1);
    add_row(OP_QUERY, 63, 0, 62, 0, 0, 0, 32'h8000_0000, 1, 1);
    // Single walked cell (5,0): compare at the extremes, strictly-above rule.
    add_row(OP_WRITE, 5, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
    add_row(OP_QUERY, 4, 0, 6, 0, 0, 0, 32'h7FFF_FFFF, 1, 1);
    add_row(OP_QUERY, 4, 0, 6, 0, 0, 0, 32'h7FFF_FFFE, 1, 0);
    // Negative ground with no blocker stores zero.
    add_row(OP_WRITE, 5, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
    add_row(OP_QUERY, 4, 0, 6, 0, 0, 0, 32'hFFFF_FFFF, 1, 0);
    add_row(OP_QUERY, 4, 0, 6, 0, 0, 0, 32'h0000_0000, 1, 1);
    add_row(OP_WRITE, 5, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    add_row(OP_QUERY, 4, 0, 6, 0, 0, 0, 32'h8000_0000, 1, 1);
    // Blocker above ground wins.
    add_row(OP_WRITE, 5, 0, 0, 0, 32'hFFFF_FFFB, 32'd3, 0, 0, 0);
    add_row(OP_QUERY, 4, 0, 6, 0, 0, 0, 32'd3, 1, 1);
    add_row(OP_QUERY, 4, 0, 6, 0, 0, 0, 32'd2, 1, 0);
    // Tall endpoints are never tested; only (1,63) lies between them.
    add_row(OP_WRITE, 0, 63, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
    add_row(OP_WRITE, 2, 63, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
    add_row(OP_WRITE, 1, 63, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_QUERY, 0, 63, 2, 63, 0, 0, 32'd0, 1, 1);
    add_row(OP_QUERY, 2, 63, 0, 63, 0, 0, 32'hFFFF_FFFF, 1, 0);
    // Long lines across the preloaded band.
    add_row(OP_QUERY, 0, 0, 63, 3, 0, 0, 32'd4, 0, 0);
    add_row(OP_QUERY, 63, 0, 0, 3, 0, 0, 32'd4, 0, 0);
    add_row(OP_QUERY, 0, 1, 63, 2, 0, 0, 32'd2, 0, 0);
    add_row(OP_QUERY, 0, 2, 63, 2, 0, 0, 32'h7FFF_FFFF, 1, 1);
    add_row(OP_QUERY, 63, 3, 0, 0, 0, 0, 32'h8000_0000, 0, 0);

    grid_w = int'(GRID_WIDTH_RESET);
    grid_h = int'(GRID_HEIGHT_RESET);

    // Hold reset, then release it on a rising edge.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < BOOT_ROWS; i++)
      issue_txn(stim_table[i].txn, stim_table[i].typed, stim_table[i].want);

    // Preload the band of rows that the long directed lines walk across.
    for (c = 0; c < BAND_ROWS * MAX_COLUMNS; c++) begin
      t.op      = OP_WRITE;
      t.sx      = COORD_BITS'(c % MAX_COLUMNS);
      t.sy      = COORD_BITS'(c / MAX_COLUMNS);
      t.tx      = COORD_BITS'($urandom_range(0, 63));
      t.ty      = COORD_BITS'($urandom_range(0, 63));
      t.ground  = rand_level();
      t.blocker = ($urandom_range(0, 2) != 0) ? '0 : rand_level();
      t.eye     = $urandom;
      if ($urandom_range(0, 63) == 0) idle_on = !idle_on;
      issue_txn(t, 1'b0, 1'b0);
    end
    idle_on = 1'b1;

    for (i = BOOT_ROWS; i < stim_table.size(); i++)
      issue_txn(stim_table[i].txn, stim_table[i].typed, stim_table[i].want);
    drain();

    // Random phases, each under its own grid size; registers change only while idle.
    for (p = 0; p < PHASE_COUNT; p++) begin
      junk     = 1'b0;
      junk_idx = REG_UNUSED_2;
      case (p)
        0: begin pw = 7'd64;  ph = 7'd64; end
        1: begin pw = 7'd1;   ph = 7'd64; junk = 1'b1; end
        2: begin pw = 7'd64;  ph = 7'd1;  end
        3: begin pw = 7'd0;   ph = 7'd9;  junk = 1'b1; junk_idx = REG_UNUSED_3; end
        4: begin pw = 7'd127; ph = 7'd127; end
        5: begin
          pw = CFG_BITS'($urandom_range(1, 64));
          ph = CFG_BITS'($urandom_range(1, 64));
        end
        6: begin pw = 7'd65;  ph = 7'd40; end
        default: begin pw = 7'd64; ph = 7'd64; end
      endcase
      program_grid(pw, ph, junk, junk_idx);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
        // Keep queries on lines whose in-grid cells were all written.
        t = random_txn();
        for (r = 0; r < QUERY_TRIES && t.op == OP_QUERY && first_unwritten(t) >= 0; r++)
          t = random_txn();
        if (t.op == OP_QUERY) begin
          u = first_unwritten(t);
          if (u >= 0) begin
            // fill the hole instead so later walks can cross it
            t.op = OP_WRITE;
            t.sx = COORD_BITS'(u % MAX_COLUMNS);
            t.sy = COORD_BITS'(u / MAX_COLUMNS);
          end
        end
        issue_txn(t, 1'b0, 1'b0);
      end
      drain();
    end

    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: end the run if the block stops answering or stops taking transactions.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
design/glos_pkg.sv
design/glos_front.sv
design/glos_queue.sv
design/glos_back.sv
design/grid_line_of_sight.sv
dv/tb_grid_line_of_sight.sv
